[src/marker_delimited_message_extractor_macros.svh]
// assertion macros used by the checker of the deframer
`ifndef MARKER_DELIMITED_MESSAGE_EXTRACTOR_MACROS_SVH
`define MARKER_DELIMITED_MESSAGE_EXTRACTOR_MACROS_SVH

// implication checked on every clock edge outside reset
`define MDME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition checked in the cycle after the antecedent
`define MDME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mdme_pkg.sv]
package mdme_pkg;

  localparam int unsigned MaxMarkerBytes = 8;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned WinW           = MaxMarkerBytes * ByteW;
  localparam int unsigned LenW           = 4;
  localparam int unsigned CntW           = 4;
  localparam int unsigned CfgIdxW        = 4;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned WinIdxW        = (MaxMarkerBytes > 1) ? $clog2(MaxMarkerBytes) : 1;
  localparam logic [CntW-1:0] CntMax     = {CntW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartPattern = 4'd0,
    CfgStartLength  = 4'd1,
    CfgEndPattern   = 4'd2,
    CfgEndLength    = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } mdme_cell_ctrl_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic             message_done;
    logic             message_dropped;
  } mdme_result_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    res = len;
    if (len == '0) begin
      res = LenW'(1);
    end else if (len > LenW'(MaxMarkerBytes)) begin
      res = LenW'(MaxMarkerBytes);
    end
    return res;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    logic [CntW-1:0] res;
    res = (v == CntMax) ? CntMax : v + CntW'(1);
    return res;
  endfunction

endpackage

[src/mdme_if.sv]
interface mdme_cfg_if;
  import mdme_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface mdme_rx_if;
  import mdme_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             buffer_last;
  modport source (output valid, output rx_byte, output buffer_last, input ready);
  modport sink   (input valid, input rx_byte, input buffer_last, output ready);
endinterface

interface mdme_res_if;
  import mdme_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  logic             payload_valid;
  logic             message_done;
  logic             message_dropped;
  modport source (output valid, output payload_byte, output payload_valid,
                  output message_done, output message_dropped, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input message_done, input message_dropped, output ready);
endinterface

[src/mdme_cell.sv]
module mdme_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mdme_pkg::mdme_cell_ctrl_t ctrl_i,
  input  logic [7:0]                byte_i,
  input  logic [7:0]                start_byte_i,
  input  logic [7:0]                end_byte_i,
  input  logic                      start_care_i,
  input  logic                      end_care_i,
  output logic [7:0]                byte_o,
  output logic                      start_hit_o,
  output logic                      end_hit_o
);
  import mdme_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;

  // compare against the byte this cell will hold after the shift
  assign start_hit_o = !start_care_i || (byte_i == start_byte_i);
  assign end_hit_o   = !end_care_i || (byte_i == end_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[src/marker_delimited_message_extractor.sv]
// channel  dir  payload                                           transfer when
// cfg_i    in   index, data                                       valid & ready
// rx_i     in   rx_byte, buffer_last                              valid & ready
// res_o    out  payload_byte, payload_valid, done, dropped        valid & ready
//
// one receive byte per cycle while rx_i is ready; the window is a row of
// eight byte cells that shift together and compare both markers in parallel
// a result is registered in res_o or in the skid entry; a two-entry output
// stage keeps rx_i ready while one result waits on a stalled sink
// configuration writes are registered, cfg_i is always ready
// reset clears parser state and sets both marker lengths to one byte
module marker_delimited_message_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdme_cfg_if.sink    cfg_i,
  mdme_rx_if.sink     rx_i,
  mdme_res_if.source  res_o
);
  import mdme_pkg::*;

  logic [WinW-1:0] start_pat_q, end_pat_q;
  logic [LenW-1:0] start_len_q, end_len_q;

  logic [LenW-1:0] slen, elen;
  logic            accept;
  mdme_cell_ctrl_t cell_ctrl;

  logic [ByteW-1:0]          cell_in  [MaxMarkerBytes];
  logic [ByteW-1:0]          cell_out [MaxMarkerBytes];
  logic [MaxMarkerBytes-1:0] start_hit, end_hit;

  logic [CntW-1:0] start_hold_q, start_hold_d, end_hold_q, end_hold_d;
  logic [CntW-1:0] seen_q, seen_d;
  logic            in_msg_q, in_msg_d;
  logic [CntW-1:0] scount, ecount, cnt;
  logic            smatch, ematch, closed_now;
  logic [WinIdxW-1:0] pidx;
  mdme_result_t    res_d;
  logic            has_result;

  mdme_result_t    out_q, skid_q;
  logic            out_valid_q, skid_valid_q;
  logic            push, pop;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pat_q <= '0;
      start_len_q <= LenW'(1);
      end_pat_q   <= '0;
      end_len_q   <= LenW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgStartPattern: start_pat_q <= cfg_i.data[WinW-1:0];
        CfgStartLength:  start_len_q <= cfg_i.data[LenW-1:0];
        CfgEndPattern:   end_pat_q   <= cfg_i.data[WinW-1:0];
        CfgEndLength:    end_len_q   <= cfg_i.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign slen = clamp_len(start_len_q);
  assign elen = clamp_len(end_len_q);

  assign rx_i.ready = !skid_valid_q;
  assign accept     = rx_i.valid && rx_i.ready;

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && rx_i.buffer_last;

  // byte cell row, newest byte in cell 0
  for (genvar i = 0; i < MaxMarkerBytes; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = rx_i.rx_byte;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end
    mdme_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .byte_i       (cell_in[i]),
      .start_byte_i (start_pat_q[i*ByteW +: ByteW]),
      .end_byte_i   (end_pat_q[i*ByteW +: ByteW]),
      .start_care_i (LenW'(i) < slen),
      .end_care_i   (LenW'(i) < elen),
      .byte_o       (cell_out[i]),
      .start_hit_o  (start_hit[i]),
      .end_hit_o    (end_hit[i])
    );
  end

  assign scount = sat_inc(start_hold_q);
  assign ecount = sat_inc(end_hold_q);
  assign smatch = (scount >= slen) && (&start_hit);
  assign ematch = (ecount >= elen) && (&end_hit);
  assign cnt    = sat_inc(seen_q);
  // payload leaves the window at the byte the end marker would start from
  assign pidx   = WinIdxW'(elen - LenW'(1));

  always_comb begin
    start_hold_d = smatch ? '0 : scount;
    end_hold_d   = ematch ? '0 : ecount;
    in_msg_d     = in_msg_q;
    seen_d       = seen_q;
    closed_now   = 1'b0;
    res_d        = '0;
    if (in_msg_q) begin
      if (cnt > elen) begin
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = cell_out[pidx];
      end
      if (ematch && (cnt >= elen)) begin
        res_d.message_done = 1'b1;
        in_msg_d           = 1'b0;
        closed_now         = 1'b1;
      end
      seen_d = cnt;
    end
    if (!in_msg_d && smatch && (!closed_now || (slen <= elen))) begin
      in_msg_d = 1'b1;
      seen_d   = '0;
    end
    if (rx_i.buffer_last) begin
      res_d.message_dropped = in_msg_d;
      start_hold_d          = '0;
      end_hold_d            = '0;
      in_msg_d              = 1'b0;
      seen_d                = '0;
    end
  end

  assign has_result = res_d.payload_valid || res_d.message_done || res_d.message_dropped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_hold_q <= '0;
      end_hold_q   <= '0;
      in_msg_q     <= 1'b0;
      seen_q       <= '0;
    end else if (accept) begin
      start_hold_q <= start_hold_d;
      end_hold_q   <= end_hold_d;
      in_msg_q     <= in_msg_d;
      seen_q       <= seen_d;
    end
  end

  // output register with skid entry
  assign push = accept && has_result;
  assign pop  = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop || !out_valid_q) begin
        out_valid_q  <= skid_valid_q || push;
        skid_valid_q <= 1'b0;
      end else if (push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.payload_byte    = out_q.payload_byte;
  assign res_o.payload_valid   = out_q.payload_valid;
  assign res_o.message_done    = out_q.message_done;
  assign res_o.message_dropped = out_q.message_dropped;

endmodule

[src/mdme_checker.sv]
`include "marker_delimited_message_extractor_macros.svh"

module mdme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] payload_byte_i,
  input logic       payload_valid_i,
  input logic       message_done_i,
  input logic       message_dropped_i
);
  import mdme_pkg::*;

  // a result always carries at least one flag
  `MDME_ASSERT_IMP(a_res_flagged, res_valid_i, payload_valid_i || message_done_i || message_dropped_i, "result without any flag")

  // no payload means a zero byte
  `MDME_ASSERT_IMP(a_byte_zero, res_valid_i && !payload_valid_i, payload_byte_i == '0, "payload byte set without payload")

  `MDME_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_i, "configuration port not ready")

  `MDME_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(payload_byte_i) && $stable(payload_valid_i) && $stable(message_done_i) && $stable(message_dropped_i), "stalled result changed")

endmodule

bind marker_delimited_message_extractor mdme_checker u_mdme_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_ready_i       (cfg_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .payload_byte_i    (res_o.payload_byte),
  .payload_valid_i   (res_o.payload_valid),
  .message_done_i    (res_o.message_done),
  .message_dropped_i (res_o.message_dropped)
);
